@@ rtl/swt_pkg.sv @@
// Shared types and constants for the shell word tokenizer.
`timescale 1ns / 1ps
`default_nettype none

package swt_pkg;

    localparam int DEF_MAX_WORDS = 16;
    localparam int DEF_MAX_LEN   = 64;

    // Results one input character can cause, and the width of a count of them
    localparam int MAX_RES   = 4;
    localparam int RES_IDX_W = $clog2(MAX_RES);
    localparam int RES_CNT_W = $clog2(MAX_RES + 1);

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_DOLLAR = 8'h24;

    typedef enum logic [2:0] {
        MODE_TOP    = 3'd0,
        MODE_ESC    = 3'd1,
        MODE_SQ     = 3'd2,
        MODE_DQ     = 3'd3,
        MODE_DQ_ESC = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        KIND_CHAR     = 2'd0,
        KIND_WORD_END = 2'd1,
        KIND_LINE_END = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data;
        logic [4:0]  word_number;
        logic [5:0]  word_length;
        logic        run_last;
    } res_t;

endpackage

`default_nettype wire

@@ rtl/swt_step.sv @@
// Next-state and result-group logic for one registered character.
`timescale 1ns / 1ps
`default_nettype none

module swt_step
    import swt_pkg::*;
#(
    parameter int MAX_WORDS = DEF_MAX_WORDS,
    parameter int MAX_LEN   = DEF_MAX_LEN,
    parameter int LEN_W     = $clog2(MAX_LEN),
    parameter int CNT_W     = $clog2(MAX_WORDS + 1)
)
(
    input  wire mode_t                     mode,
    input  wire logic [LEN_W-1:0]          len,
    input  wire logic [CNT_W-1:0]          cnt,
    input  wire logic [7:0]                ch,
    input  wire logic                      is_final,
    output mode_t                          mode_next,
    output logic [LEN_W-1:0]               len_next,
    output logic [CNT_W-1:0]               cnt_next,
    output res_t [MAX_RES-1:0]             res,
    output logic [RES_CNT_W-1:0]           res_n
);

    typedef struct packed {
        mode_t                  mode;
        logic [LEN_W-1:0]       len;
        logic [CNT_W-1:0]       cnt;
        logic [RES_CNT_W-1:0]   n;
        res_t [MAX_RES-1:0]     res;
    } work_t;

    function automatic work_t push_char(work_t w, logic [7:0] c);
        work_t r;
        r = w;
        if (w.len < LEN_W'(MAX_LEN - 1))
        begin
            r.len = w.len + 1'b1;
            r.res[w.n[RES_IDX_W-1:0]] = '{KIND_CHAR, c, 5'(w.cnt), 6'(r.len), 1'b0};
            r.n = w.n + 1'b1;
        end
        return r;
    endfunction

    function automatic work_t end_word(work_t w);
        work_t r;
        r = w;
        if (w.len != '0)
        begin
            r.res[w.n[RES_IDX_W-1:0]] =
                '{KIND_WORD_END, 8'd0, 5'(w.cnt), 6'(w.len), 1'b0};
            r.n   = w.n + 1'b1;
            r.cnt = w.cnt + 1'b1;
            r.len = '0;
        end
        r.mode = MODE_TOP;
        return r;
    endfunction

    // Close the word as soon as it is full
    function automatic work_t cap_check(work_t w);
        work_t r;
        r = w;
        if (w.len >= LEN_W'(MAX_LEN - 1))
        begin
            r = end_word(w);
        end
        return r;
    endfunction

    work_t w;

    always_comb
    begin
        w.mode = mode;
        w.len  = len;
        w.cnt  = cnt;
        w.n    = '0;
        w.res  = '0;

        if (cnt < CNT_W'(MAX_WORDS))
        begin
            unique case (mode)
                MODE_ESC:
                begin
                    w.mode = MODE_TOP;
                    w = push_char(w, ch);
                    w = cap_check(w);
                end
                MODE_SQ:
                begin
                    if (ch == CH_SQUOTE)
                    begin
                        w.mode = MODE_TOP;
                        w = cap_check(w);
                    end
                    else
                    begin
                        w = push_char(w, ch);
                    end
                end
                MODE_DQ:
                begin
                    if (ch == CH_DQUOTE)
                    begin
                        w.mode = MODE_TOP;
                        w = cap_check(w);
                    end
                    else if (ch == CH_BSLASH)
                    begin
                        // keep a trailing backslash literally
                        if (is_final)
                        begin
                            w = push_char(w, CH_BSLASH);
                        end
                        else
                        begin
                            w.mode = MODE_DQ_ESC;
                        end
                    end
                    else
                    begin
                        w = push_char(w, ch);
                    end
                end
                MODE_DQ_ESC:
                begin
                    w.mode = MODE_DQ;
                    if (ch == CH_BSLASH || ch == CH_DQUOTE || ch == CH_DOLLAR)
                    begin
                        w = push_char(w, ch);
                    end
                    else
                    begin
                        w = push_char(w, CH_BSLASH);
                        w = push_char(w, ch);
                    end
                end
                default:
                begin
                    w.mode = MODE_TOP;
                    if (ch == CH_SPACE || ch == CH_TAB)
                    begin
                        w = end_word(w);
                    end
                    else if (ch == CH_BSLASH)
                    begin
                        w.mode = MODE_ESC;
                    end
                    else if (ch == CH_SQUOTE)
                    begin
                        w.mode = MODE_SQ;
                    end
                    else if (ch == CH_DQUOTE)
                    begin
                        w.mode = MODE_DQ;
                    end
                    else
                    begin
                        w = push_char(w, ch);
                        w = cap_check(w);
                    end
                end
            endcase
        end

        if (is_final)
        begin
            w = end_word(w);
            w.res[w.n[RES_IDX_W-1:0]] = '{KIND_LINE_END, 8'd0, 5'(w.cnt), 6'd0, 1'b0};
            w.n    = w.n + 1'b1;
            w.mode = MODE_TOP;
            w.len  = '0;
            w.cnt  = '0;
        end

        // flag the last result of the group
        for (int i = 0; i < MAX_RES; i++)
        begin
            w.res[i].run_last = (RES_CNT_W'(i + 1) == w.n);
        end
    end

    assign mode_next = w.mode;
    assign len_next  = w.len;
    assign cnt_next  = w.cnt;
    assign res       = w.res;
    assign res_n     = w.n;

endmodule

`default_nettype wire

@@ rtl/swt_outq.sv @@
// Result group register that hands out one result beat per cycle while res_ready is high.
`timescale 1ns / 1ps
`default_nettype none

module swt_outq
    import swt_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   load,
    input  wire res_t [MAX_RES-1:0]     load_res,
    input  wire logic [RES_CNT_W-1:0]   load_n,
    output logic                        can_load,
    output logic                        res_valid,
    input  wire logic                   res_ready,
    output res_t                        head
);

    res_t [MAX_RES-1:0]     q_reg;
    res_t [MAX_RES-1:0]     q_next;
    logic [RES_CNT_W-1:0]   n_reg;
    logic [RES_CNT_W-1:0]   n_next;
    logic                   pop;

    assign res_valid = (n_reg != '0);
    assign pop       = res_valid && res_ready;
    // free once the last beat of the group leaves
    assign can_load  = (n_reg == '0) || (n_reg == RES_CNT_W'(1) && res_ready);
    assign head      = q_reg[0];

    always_comb
    begin
        q_next = q_reg;
        n_next = n_reg;
        if (load)
        begin
            q_next = load_res;
            n_next = load_n;
        end
        else if (pop)
        begin
            for (int i = 0; i < MAX_RES - 1; i++)
            begin
                q_next[i] = q_reg[i + 1];
            end
            n_next = n_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg <= '0;
        end
        else
        begin
            n_reg <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

endmodule

`default_nettype wire

@@ rtl/shell_word_tokenizer_core.sv @@
// Top level of the shell word tokenizer: input register, scan state, result queue.
//
//  channel  direction  handshake                payload
//  item     in         item_valid / item_ready  ch, is_final
//  res      out        res_valid / res_ready    kind, data, word_number, word_length, run_last
//
// One character is registered, then decoded combinationally into a group of up to
// four result beats held in the result queue. The next character waits in the input
// register until the last beat of the group leaves through the single result port.
// Reset returns the scanner to between words with no word counted. A stalled res_ready
// holds the group and, once the input register is full, item_ready.
`timescale 1ns / 1ps
`default_nettype none

module shell_word_tokenizer_core
    import swt_pkg::*;
#(
    parameter int MAX_WORDS = DEF_MAX_WORDS,
    parameter int MAX_LEN   = DEF_MAX_LEN
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    output logic             item_ready,
    input  wire logic [7:0]  ch,
    input  wire logic        is_final,
    output logic             res_valid,
    input  wire logic        res_ready,
    output logic [1:0]       kind,
    output logic [7:0]       data,
    output logic [4:0]       word_number,
    output logic [5:0]       word_length,
    output logic             run_last
);

    localparam int LEN_W = $clog2(MAX_LEN);
    localparam int CNT_W = $clog2(MAX_WORDS + 1);

    logic                   in_valid_reg;
    logic [7:0]             ch_reg;
    logic                   fin_reg;

    mode_t                  mode_reg;
    mode_t                  mode_next;
    logic [LEN_W-1:0]       len_reg;
    logic [LEN_W-1:0]       len_next;
    logic [CNT_W-1:0]       cnt_reg;
    logic [CNT_W-1:0]       cnt_next;

    res_t [MAX_RES-1:0]     grp_res;
    logic [RES_CNT_W-1:0]   grp_n;
    logic                   can_load;
    logic                   advance;
    res_t                   head;

    assign advance    = in_valid_reg && can_load;
    assign item_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            mode_reg     <= MODE_TOP;
            len_reg      <= '0;
            cnt_reg      <= '0;
        end
        else
        begin
            if (item_ready)
            begin
                in_valid_reg <= item_valid;
            end
            if (advance)
            begin
                mode_reg <= mode_next;
                len_reg  <= len_next;
                cnt_reg  <= cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            ch_reg  <= ch;
            fin_reg <= is_final;
        end
    end

    swt_step #(
        .MAX_WORDS (MAX_WORDS),
        .MAX_LEN   (MAX_LEN),
        .LEN_W     (LEN_W),
        .CNT_W     (CNT_W)
    ) u_step (
        .mode      (mode_reg),
        .len       (len_reg),
        .cnt       (cnt_reg),
        .ch        (ch_reg),
        .is_final  (fin_reg),
        .mode_next (mode_next),
        .len_next  (len_next),
        .cnt_next  (cnt_next),
        .res       (grp_res),
        .res_n     (grp_n)
    );

    swt_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .load_res  (grp_res),
        .load_n    (grp_n),
        .can_load  (can_load),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .head      (head)
    );

    assign kind        = head.kind;
    assign data        = head.data;
    assign word_number = head.word_number;
    assign word_length = head.word_length;
    assign run_last    = head.run_last;

endmodule

`default_nettype wire

@@ test/tb_shell_word_tokenizer_core.sv @@
// Testbench for the shell word tokenizer core: random word streams checked against a predictor.
`timescale 1ns / 1ps

import swt_pkg::*;

// Predicts the beats each character causes and checks them in order.
class tokenizer_scoreboard;
    mode_t       mode;
    logic [5:0]  wlen;
    logic [4:0]  wcount;
    res_t        group[$];
    res_t        expected_beats[$];
    int          errors;

    function new();
        mode   = MODE_TOP;
        wlen   = '0;
        wcount = '0;
        errors = 0;
    endfunction

    function void emit_beat(kind_t k, logic [7:0] d, logic [4:0] n, logic [5:0] l);
        res_t r;
        r.kind        = k;
        r.data        = d;
        r.word_number = n;
        r.word_length = l;
        r.run_last    = 1'b0;
        group.push_back(r);
    endfunction

    // Past the length cap, characters are dropped.
    function void append_char(logic [7:0] c);
        if (wlen < DEF_MAX_LEN - 1)
        begin
            wlen = wlen + 6'd1;
            emit_beat(KIND_CHAR, c, wcount, wlen);
        end
    endfunction

    function void close_word();
        if (wlen > 0)
        begin
            emit_beat(KIND_WORD_END, 8'h00, wcount, wlen);
            wcount = wcount + 5'd1;
            wlen   = '0;
        end
        mode = MODE_TOP;
    endfunction

    function void close_if_full();
        if (wlen >= DEF_MAX_LEN - 1)
            close_word();
    endfunction

    // Returns 1 when the character is not ignored by the word limit.
    function bit note_char(logic [7:0] c, logic fin);
        bit active;
        active = (wcount < DEF_MAX_WORDS);
        group.delete();
        if (active)
        begin
            case (mode)
                MODE_ESC:
                begin
                    mode = MODE_TOP;
                    append_char(c);
                    close_if_full();
                end
                MODE_SQ:
                begin
                    if (c == CH_SQUOTE)
                    begin
                        mode = MODE_TOP;
                        close_if_full();
                    end
                    else
                        append_char(c);
                end
                MODE_DQ:
                begin
                    if (c == CH_DQUOTE)
                    begin
                        mode = MODE_TOP;
                        close_if_full();
                    end
                    else if (c == CH_BSLASH)
                    begin
                        if (fin)
                            append_char(CH_BSLASH);
                        else
                            mode = MODE_DQ_ESC;
                    end
                    else
                        append_char(c);
                end
                MODE_DQ_ESC:
                begin
                    mode = MODE_DQ;
                    if (c == CH_BSLASH || c == CH_DQUOTE || c == CH_DOLLAR)
                        append_char(c);
                    else
                    begin
                        append_char(CH_BSLASH);
                        append_char(c);
                    end
                end
                default:
                begin
                    mode = MODE_TOP;
                    if (c == CH_SPACE || c == CH_TAB)
                        close_word();
                    else if (c == CH_BSLASH)
                        mode = MODE_ESC;
                    else if (c == CH_SQUOTE)
                        mode = MODE_SQ;
                    else if (c == CH_DQUOTE)
                        mode = MODE_DQ;
                    else
                    begin
                        append_char(c);
                        close_if_full();
                    end
                end
            endcase
        end
        if (fin)
        begin
            close_word();
            emit_beat(KIND_LINE_END, 8'h00, wcount, 6'd0);
            mode   = MODE_TOP;
            wlen   = '0;
            wcount = '0;
        end
        if (group.size() > 0)
            group[group.size() - 1].run_last = 1'b1;
        foreach (group[i])
            expected_beats.push_back(group[i]);
        return active;
    endfunction

    function int pending();
        return expected_beats.size();
    endfunction

    function void check_beat(logic [1:0] k, logic [7:0] d, logic [4:0] n, logic [5:0] l,
                             logic last);
        res_t want;
        bit   bad;
        if (expected_beats.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("%0t: unexpected beat kind=%0d data=%02h num=%0d len=%0d last=%0d",
                         $time, k, d, n, l, last);
            return;
        end
        want = expected_beats.pop_front();
        bad  = 1'b0;
        if (kind_t'(k) !== want.kind)       bad = 1'b1;
        if (d !== want.data)                bad = 1'b1;
        if (n !== want.word_number)         bad = 1'b1;
        if (l !== want.word_length)         bad = 1'b1;
        if (last !== want.run_last)         bad = 1'b1;
        if (bad)
        begin
            errors++;
            if (errors <= 10)
            begin
                $write("%0t: mismatch exp kind=%0d data=%02h num=%0d len=%0d last=%0d, ",
                       $time, want.kind, want.data, want.word_number, want.word_length,
                       want.run_last);
                $display("got kind=%0d data=%02h num=%0d len=%0d last=%0d",
                         k, d, n, l, last);
            end
        end
    endfunction
endclass

module tb_shell_word_tokenizer_core;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        item_valid;
    logic        item_ready;
    logic [7:0]  ch;
    logic        is_final;
    logic        res_valid;
    logic        res_ready;
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [4:0]  word_number;
    logic [5:0]  word_length;
    logic        run_last;

    tokenizer_scoreboard sb;
    logic [7:0]          line_buf[$];
    bit                  idle_on;
    int                  counted_items;
    int                  stall_left;

    shell_word_tokenizer_core #(
        .MAX_WORDS (DEF_MAX_WORDS),
        .MAX_LEN   (DEF_MAX_LEN)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .ch          (ch),
        .is_final    (is_final),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .kind        (kind),
        .data        (data),
        .word_number (word_number),
        .word_length (word_length),
        .run_last    (run_last)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Result side: ready with random stall bursts.
    initial
    begin
        res_ready  = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (!rst_n)
                res_ready = 1'b0;
            else if (stall_left > 0)
            begin
                res_ready = 1'b0;
                stall_left--;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                res_ready  = 1'b0;
                stall_left = $urandom_range(1, 18) - 1;
            end
            else
                res_ready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
            sb.check_beat(kind, data, word_number, word_length, run_last);
    end

    task automatic send_char(input logic [7:0] c, input logic fin);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            item_valid = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        item_valid = 1'b1;
        ch         = c;
        is_final   = fin;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        if (sb.note_char(c, fin))
            counted_items++;
        @(negedge clk);
    endtask

    // Send the buffered line; the last character ends it.
    task automatic send_line();
        foreach (line_buf[i])
            send_char(line_buf[i], i == line_buf.size() - 1);
        line_buf.delete();
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endtask

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(8'h21, 8'h7E));
        while (c == CH_BSLASH || c == CH_SQUOTE || c == CH_DQUOTE);
        return c;
    endfunction

    function automatic logic [7:0] any_char();
        return 8'($urandom_range(1, 255));
    endfunction

    function automatic logic [7:0] blank();
        return $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
    endfunction

    function automatic void add_word();
        repeat ($urandom_range(1, 4))
        begin
            case ($urandom_range(0, 9))
                5:
                begin
                    line_buf.push_back(CH_BSLASH);
                    line_buf.push_back(any_char());
                end
                6:
                begin
                    line_buf.push_back(CH_SQUOTE);
                    repeat ($urandom_range(0, 5)) line_buf.push_back(any_char());
                    line_buf.push_back(CH_SQUOTE);
                end
                7:
                begin
                    line_buf.push_back(CH_DQUOTE);
                    repeat ($urandom_range(0, 5))
                    begin
                        case ($urandom_range(0, 3))
                            0:
                            begin
                                line_buf.push_back(CH_BSLASH);
                                case ($urandom_range(0, 2))
                                    0:       line_buf.push_back(CH_BSLASH);
                                    1:       line_buf.push_back(CH_DQUOTE);
                                    default: line_buf.push_back(CH_DOLLAR);
                                endcase
                            end
                            1:
                            begin
                                line_buf.push_back(CH_BSLASH);
                                line_buf.push_back(any_char());
                            end
                            default: line_buf.push_back(plain_char());
                        endcase
                    end
                    line_buf.push_back(CH_DQUOTE);
                end
                8: line_buf.push_back(any_char());
                9:
                begin
                    if ($urandom_range(0, 1))
                    begin
                        line_buf.push_back(CH_SQUOTE);
                        line_buf.push_back(CH_SQUOTE);
                    end
                    else
                    begin
                        line_buf.push_back(CH_DQUOTE);
                        line_buf.push_back(CH_DQUOTE);
                    end
                end
                default:
                    repeat ($urandom_range(1, 4)) line_buf.push_back(plain_char());
            endcase
        end
    endfunction

    task automatic send_random_line();
        int words;
        words = $urandom_range(1, 5);
        if ($urandom_range(0, 3) == 0)
            line_buf.push_back(blank());
        for (int w = 0; w < words; w++)
        begin
            if (w > 0)
                repeat ($urandom_range(1, 3)) line_buf.push_back(blank());
            add_word();
        end
        // Odd line endings: trailing blank, dangling backslash, open quotes.
        case ($urandom_range(0, 7))
            0: line_buf.push_back(blank());
            1: line_buf.push_back(CH_BSLASH);
            2:
            begin
                line_buf.push_back(CH_DQUOTE);
                line_buf.push_back(plain_char());
                line_buf.push_back(CH_BSLASH);
            end
            3:
            begin
                line_buf.push_back(CH_SQUOTE);
                line_buf.push_back(plain_char());
            end
            default: ;
        endcase
        send_line();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        item_valid    = 1'b0;
        ch            = 8'h00;
        is_final      = 1'b0;
        idle_on       = 1'b1;
        counted_items = 0;
        sb            = new();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Byte extremes, zero byte, escapes, quotes, trailing backslashes, open quote.
        line_buf = {8'hFF, 8'h01, CH_SPACE};
        send_line();
        line_buf = {8'h00};
        send_line();
        queue_text("\\ a''");
        send_line();
        queue_text("\"\\\\\\q\\");
        send_line();
        queue_text("\"\\\"\\$\"\t");
        send_line();
        queue_text("a\\");
        send_line();
        queue_text("'b");
        send_line();

        counted_items = 0;

        // Word hits the length cap unquoted, then quoted.
        repeat (70) line_buf.push_back(plain_char());
        line_buf.push_back(CH_SPACE);
        line_buf.push_back(plain_char());
        send_line();
        line_buf.push_back($urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE);
        repeat (70) line_buf.push_back(plain_char());
        line_buf.push_back(line_buf[0]);
        line_buf.push_back(plain_char());
        send_line();

        // More words than the limit on one line.
        repeat (18)
        begin
            line_buf.push_back(plain_char());
            line_buf.push_back(blank());
        end
        add_word();
        send_line();

        while (counted_items < 280)
        begin
            if (counted_items >= 230)
                idle_on = 1'b0;
            send_random_line();
        end
        item_valid = 1'b0;

        for (int guard = 0; guard < 5000 && sb.pending() > 0; guard++)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ files.f @@
rtl/swt_pkg.sv
rtl/swt_step.sv
rtl/swt_outq.sv
rtl/shell_word_tokenizer_core.sv
test/tb_shell_word_tokenizer_core.sv
